@@ rtl/scaled_texture_blit_top_defines.svh @@
// Assertion macros for the verification files of the texture blitter.
// Depends on nothing; included by the checker module.
`ifndef SCALED_TEXTURE_BLIT_TOP_DEFINES_SVH
`define SCALED_TEXTURE_BLIT_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define STB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define STB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/stb_pkg.sv @@
// Shared types and constants of the scaled texture blitter.
// Used by the top level and by the checker; depends on nothing.
package stb_pkg;

  // Sizes of the stores and of the destination rectangle.
  localparam int unsigned TEXTURE_DEPTH = 65536;
  localparam int unsigned MAX_RECT_SIDE = 1024;
  localparam int unsigned TEX_AW        = $clog2(TEXTURE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(MAX_RECT_SIDE);
  localparam int unsigned SIDE_W        = CNT_W + 1;
  localparam int unsigned REMAP_DEPTH   = 256;
  localparam int unsigned BLEND_DEPTH   = 65536;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_START   = 3'd0,
    CFG_ROW_START      = 3'd1,
    CFG_COLUMN_STEP    = 3'd2,
    CFG_ROW_STEP       = 3'd3,
    CFG_TEXTURE_HEIGHT = 3'd4,
    CFG_RECT_WIDTH     = 3'd5,
    CFG_RECT_HEIGHT    = 3'd6,
    CFG_EFFECT_FLAGS   = 3'd7
  } cfg_idx_e;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_TEXEL = 2'd0,
    MODE_REMAP = 2'd1,
    MODE_BLEND = 2'd2,
    MODE_DRAW  = 2'd3
  } mode_e;

  // Bits of the effect flags register.
  localparam int unsigned FX_REMAP = 0;
  localparam int unsigned FX_BLEND = 1;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] load_index;
    logic [7:0]  load_value;
    logic [7:0]  dest_pixel;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
    logic       last;
    logic       fault;
  } out_rsp_t;

  // Request state carried down the pipeline.
  typedef struct packed {
    mode_e            mode;
    logic [15:0]      load_index;
    logic [7:0]       load_value;
    logic [7:0]       dest_pixel;
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] y;
    logic             last;
    logic             fault;
  } stage_t;

endpackage

@@ rtl/scaled_texture_blit_top.sv @@
// Scaled texture blitter; draw results leave the pipeline from its last stage.
// Five pipeline stages: position, texel address, texture read, remap read, blend read.
// Each store is read and written in its own stage, so loads and draws stay ordered.
// Throughput is one request per clock while the result side takes results.
// Reset clears the counters, the pipeline valids and the registers to their defaults;
// the texture, remap and blend stores are not cleared and need no clearing pass.
module scaled_texture_blit_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stb_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stb_pkg::out_rsp_t               out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [stb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import stb_pkg::*;

  // Clamp a rectangle side to one through the largest side.
  function automatic logic [SIDE_W-1:0] side_lim(input logic [10:0] v);
    logic [SIDE_W-1:0] r;
    if (v == 11'd0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > MAX_RECT_SIDE) begin
      r = SIDE_W'(MAX_RECT_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [24:0] col_start_q, row_start_q, row_step_q;
  logic [25:0] col_step_q;
  logic [8:0]  tex_h_q;
  logic [10:0] rect_w_q, rect_h_q;
  logic [1:0]  fx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_start_q <= '0;
      row_start_q <= '0;
      col_step_q  <= 26'd65536;
      row_step_q  <= 25'd65536;
      tex_h_q     <= 9'd64;
      rect_w_q    <= 11'd1;
      rect_h_q    <= 11'd1;
      fx_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMN_START:   col_start_q <= cfg_data_i[24:0];
        CFG_ROW_START:      row_start_q <= cfg_data_i[24:0];
        CFG_COLUMN_STEP:    col_step_q  <= cfg_data_i[25:0];
        CFG_ROW_STEP:       row_step_q  <= cfg_data_i[24:0];
        CFG_TEXTURE_HEIGHT: tex_h_q     <= cfg_data_i[8:0];
        CFG_RECT_WIDTH:     rect_w_q    <= cfg_data_i[10:0];
        CFG_RECT_HEIGHT:    rect_h_q    <= cfg_data_i[10:0];
        CFG_EFFECT_FLAGS:   fx_q        <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline payload registers.
  stage_t            st1_q, st2_q, st3_q, st4_q, st5_q;
  logic [31:0]       col1_q, row1_q;
  logic [TEX_AW-1:0] taddr2_q;
  logic [7:0]        texel4_q, pix5_q;

  // Stage valids and advance chain; a stage loads when empty or when it drains.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;
  logic in_acc;

  assign adv5       = !v5_q || (st5_q.mode != MODE_DRAW) || out_ready_i;
  assign adv4       = !v4_q || adv5;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign in_acc     = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  // Walk state: destination counters and texture position accumulators.
  logic [CNT_W-1:0]  x_q, x_d, y_q, y_d;
  logic [31:0]       col_q, col_d, row_q, row_d;
  logic [SIDE_W-1:0] w, h;
  logic [CNT_W-1:0]  xe, ye;
  logic              at_start, col_end, is_last, is_draw;
  logic [31:0]       col_cur, row_cur;

  always_comb begin
    w        = side_lim(rect_w_q);
    h        = side_lim(rect_h_q);
    is_draw  = (in_req_i.mode == MODE_DRAW);
    // A size that shrank below the counters restarts the rectangle.
    if ({1'b0, x_q} >= w || {1'b0, y_q} >= h) begin
      xe = '0;
      ye = '0;
    end else begin
      xe = x_q;
      ye = y_q;
    end
    at_start = (xe == '0) && (ye == '0);
    col_cur  = at_start ? 32'(col_start_q) : col_q;
    row_cur  = at_start ? 32'(row_start_q) : row_q;
    col_end  = (SIDE_W'(ye) + SIDE_W'(1)) >= h;
    is_last  = col_end && ((SIDE_W'(xe) + SIDE_W'(1)) >= w);
    // Next position: down the column, to the next column, or back to the origin.
    x_d   = xe;
    y_d   = ye;
    col_d = col_cur;
    row_d = row_cur;
    if (!col_end) begin
      y_d   = ye + CNT_W'(1);
      row_d = row_cur + 32'(row_step_q);
    end else if (!is_last) begin
      y_d   = '0;
      x_d   = xe + CNT_W'(1);
      col_d = col_cur + {{6{col_step_q[25]}}, col_step_q};
      row_d = 32'(row_start_q);
    end else begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc && is_draw) begin
      x_q   <= x_d;
      y_q   <= y_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Texel address: height times integer column plus integer row.
  logic [23:0] prod;
  logic [24:0] texel;
  logic        tex_fault;
  stage_t      st2_d;

  always_comb begin
    prod        = 24'(tex_h_q) * 24'(col1_q[30:16]);
    texel       = 25'(prod) + 25'(row1_q[31:16]);
    tex_fault   = col1_q[31] || (texel >= 25'(TEXTURE_DEPTH));
    st2_d       = st1_q;
    st2_d.fault = tex_fault;
  end

  // Store read data.
  logic [7:0] tex_rdata, remap_rdata, blend_rdata;
  logic [7:0] pix4;

  assign pix4 = fx_q[FX_REMAP] ? remap_rdata : texel4_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      st1_q.mode       <= in_req_i.mode;
      st1_q.load_index <= in_req_i.load_index;
      st1_q.load_value <= in_req_i.load_value;
      st1_q.dest_pixel <= in_req_i.dest_pixel;
      st1_q.x          <= xe;
      st1_q.y          <= ye;
      st1_q.last       <= is_last;
      st1_q.fault      <= 1'b0;
      col1_q           <= col_cur;
      row1_q           <= row_cur;
    end
    if (adv2) begin
      st2_q    <= st2_d;
      taddr2_q <= texel[TEX_AW-1:0];
    end
    if (adv3) begin
      st3_q <= st2_q;
    end
    if (adv4) begin
      st4_q    <= st3_q;
      texel4_q <= tex_rdata;
    end
    if (adv5) begin
      st5_q  <= st4_q;
      pix5_q <= pix4;
    end
  end

  // Texture store: written and read as a request leaves stage two.
  logic tex_we;
  assign tex_we = v2_q && (st2_q.mode == MODE_TEXEL) && adv3 &&
                  (32'(st2_q.load_index) < TEXTURE_DEPTH);

  stb_ram #(.DataWidth(8), .Depth(TEXTURE_DEPTH)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (TEX_AW'(st2_q.load_index)),
    .wdata_i (st2_q.load_value),
    .re_i    (adv3),
    .raddr_i (taddr2_q),
    .rdata_o (tex_rdata)
  );

  // Remap table: written and read as a request leaves stage three.
  logic remap_we;
  assign remap_we = v3_q && (st3_q.mode == MODE_REMAP) && adv4 &&
                    (st3_q.load_index[15:8] == 8'd0);

  stb_ram #(.DataWidth(8), .Depth(REMAP_DEPTH)) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (remap_we),
    .waddr_i (st3_q.load_index[7:0]),
    .wdata_i (st3_q.load_value),
    .re_i    (adv4),
    .raddr_i (tex_rdata),
    .rdata_o (remap_rdata)
  );

  // Blend table: indexed by the new pixel and the old one.
  logic blend_we;
  assign blend_we = v4_q && (st4_q.mode == MODE_BLEND) && adv5;

  stb_ram #(.DataWidth(8), .Depth(BLEND_DEPTH)) u_blend_ram (
    .clk_i   (clk_i),
    .we_i    (blend_we),
    .waddr_i (st4_q.load_index),
    .wdata_i (st4_q.load_value),
    .re_i    (adv5),
    .raddr_i ({pix4, st4_q.dest_pixel}),
    .rdata_o (blend_rdata)
  );

  // Result; a faulting texel passes the old pixel through.
  always_comb begin
    out_valid_o      = v5_q && (st5_q.mode == MODE_DRAW);
    out_rsp_o.dest_x = 10'(st5_q.x);
    out_rsp_o.dest_y = 10'(st5_q.y);
    out_rsp_o.last   = st5_q.last;
    out_rsp_o.fault  = st5_q.fault;
    if (st5_q.fault) begin
      out_rsp_o.pixel = st5_q.dest_pixel;
    end else if (fx_q[FX_BLEND]) begin
      out_rsp_o.pixel = blend_rdata;
    end else begin
      out_rsp_o.pixel = pix5_q;
    end
  end

endmodule

@@ rtl/stb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; instanced for every store of the blitter.
module stb_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth     = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/stb_checker.sv @@
// Port-level checker for the scaled texture blitter, bound to the top level.
// Depends on stb_pkg and on the assertion macros header.
`include "scaled_texture_blit_top_defines.svh"

module stb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input stb_pkg::in_req_t                in_req_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input stb_pkg::out_rsp_t               out_rsp_o
);
  import stb_pkg::*;

  logic       draw_acc, out_acc;
  logic [3:0] pend_q, pend_d;
  logic       fresh_q, fresh_d;

  assign draw_acc = in_valid_i && in_ready_o && (in_req_i.mode == MODE_DRAW);
  assign out_acc  = out_valid_o && out_ready_i;

  // Draw requests in flight, and whether the next result opens a rectangle.
  always_comb begin
    pend_d  = pend_q + 4'(draw_acc) - 4'(out_acc);
    fresh_d = out_acc ? out_rsp_o.last : fresh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      fresh_q <= 1'b1;
    end else begin
      pend_q  <= pend_d;
      fresh_q <= fresh_d;
    end
  end

  `STB_ASSERT_RST(a_quiet_in_reset, clk_i, !rst_ni |-> !out_valid_o, "Result shown during reset")
  `STB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "Stalled result changed")
  `STB_ASSERT(a_no_phantom, clk_i, rst_ni, out_valid_o |-> pend_q != 4'd0, "Result without a pending draw request")
  `STB_ASSERT(a_rect_origin, clk_i, rst_ni, out_acc && fresh_q |-> out_rsp_o.dest_x == 10'd0 && out_rsp_o.dest_y == 10'd0, "New rectangle does not start at the origin")

endmodule

bind scaled_texture_blit_top stb_checker u_stb_checker (.*);

@@ bench/tb_scaled_texture_blit_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of scaled_texture_blit_top: loads, draws and register settings.
// Uses the stb_pkg types and the top level only; results are predicted inside the bench.
module tb_scaled_texture_blit_top;
  import stb_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam longint unsigned TIMEOUT_NS = 8_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_req_t           in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_rsp_t          out_rsp_o;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Register copies, with their reset values.
  logic [24:0] col_start_q  = 25'h0;
  logic [24:0] row_start_q  = 25'h0;
  logic [25:0] col_step_q   = 26'h001_0000;
  logic [24:0] row_step_q   = 25'h001_0000;
  logic [8:0]  tex_height_q = 9'd64;
  logic [10:0] rect_w_q     = 11'd1;
  logic [10:0] rect_h_q     = 11'd1;
  logic [1:0]  fx_q         = 2'b00;

  // Walk state of the rectangle.
  logic [31:0] col_pos = '0;
  logic [31:0] row_pos = '0;
  int unsigned x_cnt   = 0;
  int unsigned y_cnt   = 0;

  // Stores and which of their entries have been written.
  logic [7:0] texel_mem [TEXTURE_DEPTH];
  logic [7:0] remap_mem [REMAP_DEPTH];
  logic [7:0] blend_mem [BLEND_DEPTH];
  bit         texel_seen [TEXTURE_DEPTH];
  bit         remap_seen [REMAP_DEPTH];
  bit         blend_seen [BLEND_DEPTH];

  out_rsp_t    pixel_queue [$];
  int unsigned error_count   = 0;
  int unsigned requests_sent = 0;
  bit          sender_gaps   = 1'b0;
  bit          sink_gaps     = 1'b0;
  bit          hold_request  = 1'b0;

  scaled_texture_blit_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // A zero side counts as one; oversized sides saturate.
  function automatic int unsigned side_clamp(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_RECT_SIDE) return MAX_RECT_SIDE;
    return v;
  endfunction

  // Counters and positions that the next draw request will use.
  function automatic void next_origin(output logic [31:0] cpos, output logic [31:0] rpos,
                                      output int unsigned xc, output int unsigned yc);
    xc   = x_cnt;
    yc   = y_cnt;
    cpos = col_pos;
    rpos = row_pos;
    if (xc >= side_clamp(rect_w_q) || yc >= side_clamp(rect_h_q)) begin
      xc = 0;
      yc = 0;
    end
    if (xc == 0 && yc == 0) begin
      cpos = {7'b0, col_start_q};
      rpos = {7'b0, row_start_q};
    end
  endfunction

  // Texel address of a position; returns 1 when the position is off the store.
  function automatic logic texel_fault(input logic [31:0] cpos, input logic [31:0] rpos,
                                       output logic [15:0] addr);
    longint unsigned stride, column, row, texel;
    stride = tex_height_q;
    column = cpos[31:16];
    row    = rpos[31:16];
    texel  = stride * column + row;
    addr   = texel[15:0];
    return cpos[31] || texel >= TEXTURE_DEPTH;
  endfunction

  // Applies one accepted request and queues the pixel it produces, if any.
  function automatic void predict_blit(input in_req_t req);
    logic [31:0] cpos, rpos;
    int unsigned xc, yc, w, h;
    logic [15:0] addr;
    logic        col_end, is_last;
    out_rsp_t    rsp;
    case (req.mode)
      // Every 16-bit index lies inside the texture store.
      MODE_TEXEL: begin
        texel_mem[req.load_index]  = req.load_value;
        texel_seen[req.load_index] = 1'b1;
      end
      MODE_REMAP: begin
        if (req.load_index < REMAP_DEPTH) begin
          remap_mem[req.load_index]  = req.load_value;
          remap_seen[req.load_index] = 1'b1;
        end
      end
      MODE_BLEND: begin
        blend_mem[req.load_index]  = req.load_value;
        blend_seen[req.load_index] = 1'b1;
      end
      default: begin
        w = side_clamp(rect_w_q);
        h = side_clamp(rect_h_q);
        next_origin(cpos, rpos, xc, yc);
        rsp.pixel = req.dest_pixel;
        rsp.fault = 1'b1;
        if (!texel_fault(cpos, rpos, addr)) begin
          rsp.fault = 1'b0;
          rsp.pixel = texel_mem[addr];
          if (fx_q[FX_REMAP]) rsp.pixel = remap_mem[rsp.pixel];
          if (fx_q[FX_BLEND]) rsp.pixel = blend_mem[{rsp.pixel, req.dest_pixel}];
        end
        col_end  = (yc + 1 >= h);
        is_last  = col_end && (xc + 1 >= w);
        rsp.dest_x = xc[9:0];
        rsp.dest_y = yc[9:0];
        rsp.last   = is_last;
        pixel_queue.push_back(rsp);
        // Step down the column, then over to the next column, then back to the origin.
        col_pos = cpos;
        row_pos = rpos;
        if (!col_end) begin
          x_cnt   = xc;
          y_cnt   = yc + 1;
          row_pos = rpos + {7'b0, row_step_q};
        end else if (!is_last) begin
          x_cnt   = xc + 1;
          y_cnt   = 0;
          col_pos = cpos + {{6{col_step_q[25]}}, col_step_q};
          row_pos = {7'b0, row_start_q};
        end else begin
          x_cnt = 0;
          y_cnt = 0;
        end
      end
    endcase
  endfunction

  function automatic in_req_t make_req(input mode_e mode, input logic [15:0] index,
                                       input logic [7:0] value, input logic [7:0] old);
    in_req_t req;
    req.mode       = mode;
    req.load_index = index;
    req.load_value = value;
    req.dest_pixel = old;
    return req;
  endfunction

  // Offers one request, with an optional idle burst first, and predicts it on acceptance.
  task automatic send_request(input in_req_t req);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_blit(req);
    requests_sent++;
  endtask

  // Draws one pixel, first loading any store entry that the draw would read unwritten.
  task automatic draw_pixel(input logic [7:0] old);
    logic [31:0] cpos, rpos;
    int unsigned xc, yc;
    logic [15:0] addr;
    logic [7:0]  pix;
    next_origin(cpos, rpos, xc, yc);
    if (!texel_fault(cpos, rpos, addr)) begin
      if (!texel_seen[addr]) send_request(make_req(MODE_TEXEL, addr, 8'($urandom), 8'h00));
      pix = texel_mem[addr];
      if (fx_q[FX_REMAP]) begin
        if (!remap_seen[pix]) send_request(make_req(MODE_REMAP, {8'h00, pix}, 8'($urandom),
                                                    8'h00));
        pix = remap_mem[pix];
      end
      if (fx_q[FX_BLEND] && !blend_seen[{pix, old}])
        send_request(make_req(MODE_BLEND, {pix, old}, 8'($urandom), 8'h00));
    end
    send_request(make_req(MODE_DRAW, 16'($urandom), 8'($urandom), old));
  endtask

  // Register write; the port is lowered again before the next write.
  task automatic write_reg(input cfg_idx_e idx, input logic [25:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COLUMN_START:   col_start_q  = data[24:0];
      CFG_ROW_START:      row_start_q  = data[24:0];
      CFG_COLUMN_STEP:    col_step_q   = data;
      CFG_ROW_STEP:       row_step_q   = data[24:0];
      CFG_TEXTURE_HEIGHT: tex_height_q = data[8:0];
      CFG_RECT_WIDTH:     rect_w_q     = data[10:0];
      CFG_RECT_HEIGHT:    rect_h_q     = data[10:0];
      default:            fx_q         = data[1:0];
    endcase
    @(posedge clk_i);
  endtask

  // Waits until every pixel has come back and any trailing load has left the pipeline.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic bit pick_extreme();
    return $urandom_range(0, 7) == 0;
  endfunction

  // Random register setting; each register is rewritten with probability three in four.
  task automatic random_setup();
    int signed step;
    wait_idle();
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_COLUMN_START, pick_extreme() ? ($urandom_range(0, 1) ? 26'h1FF_FFFF : 26'h0)
                                                 : 26'($urandom_range(0, 32'h7_FFFF)));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_ROW_START, pick_extreme() ? ($urandom_range(0, 1) ? 26'h1FF_FFFF : 26'h0)
                                              : 26'($urandom_range(0, 32'hF_FFFF)));
    if ($urandom_range(0, 3) != 0) begin
      step = int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
      write_reg(CFG_COLUMN_STEP, pick_extreme() ? ($urandom_range(0, 1) ? 26'h1FF_FFFF
                                                                        : 26'h200_0000)
                                                : step[25:0]);
    end
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_ROW_STEP, pick_extreme() ? ($urandom_range(0, 1) ? 26'h1FF_FFFF : 26'h0)
                                             : 26'($urandom_range(0, 32'h2_0000)));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_TEXTURE_HEIGHT, pick_extreme() ? 26'($urandom_range(0, 1) ? 0
                                                         : $urandom_range(257, 511))
                                                   : 26'($urandom_range(1, 256)));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_RECT_WIDTH, pick_extreme() ? 26'($urandom_range(0, 24))
                                               : 26'($urandom_range(1, 8)));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_RECT_HEIGHT, pick_extreme() ? 26'($urandom_range(0, 24))
                                                : 26'($urandom_range(1, 8)));
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_EFFECT_FLAGS, 26'($urandom_range(0, 3)));
  endtask

  // A run of draws with stray loads mixed in.
  task automatic random_burst(input int unsigned count);
    mode_e mode;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        mode = mode_e'($urandom_range(0, 2));
        send_request(make_req(mode, 16'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 65535)),
                              8'($urandom), 8'($urandom)));
      end else begin
        draw_pixel(8'($urandom));
      end
    end
  endtask

  // Reset defaults, plus loads at the ends of the index and value ranges.
  task automatic test_defaults();
    send_request(make_req(MODE_TEXEL, 16'hFFFF, 8'hFF, 8'h00));
    send_request(make_req(MODE_BLEND, 16'h0000, 8'h00, 8'hFF));
    // Remap index above the table: dropped.
    send_request(make_req(MODE_REMAP, 16'h01FF, 8'hAA, 8'h00));
    draw_pixel(8'h00);
    draw_pixel(8'hFF);
  endtask

  // Each combination of remap and blend.
  task automatic test_effects();
    for (int f = 0; f < 4; f++) begin
      wait_idle();
      write_reg(CFG_EFFECT_FLAGS, 26'(f));
      draw_pixel(8'(f * 85));
    end
  endtask

  // Texel faults and unusual strides.
  task automatic test_texel_faults();
    // Column beyond the end of the store.
    wait_idle();
    write_reg(CFG_TEXTURE_HEIGHT, 26'd256);
    write_reg(CFG_COLUMN_START, 26'h1FF_FFFF);
    draw_pixel(8'hAA);
    // A negative step walks left of column zero on the last column.
    wait_idle();
    write_reg(CFG_COLUMN_START, 26'h001_0000);
    write_reg(CFG_COLUMN_STEP, 26'h3FF_0000);
    write_reg(CFG_RECT_WIDTH, 26'd3);
    repeat (3) draw_pixel(8'h55);
    // Zero stride aliases every column onto column zero; rows at their maximum.
    wait_idle();
    write_reg(CFG_TEXTURE_HEIGHT, 26'd0);
    write_reg(CFG_ROW_START, 26'h1FF_FFFF);
    write_reg(CFG_ROW_STEP, 26'h1FF_FFFF);
    write_reg(CFG_RECT_WIDTH, 26'd1);
    write_reg(CFG_RECT_HEIGHT, 26'd2);
    repeat (2) draw_pixel(8'($urandom));
    // Stride wider than the texture.
    wait_idle();
    write_reg(CFG_TEXTURE_HEIGHT, 26'h1FF);
    write_reg(CFG_COLUMN_STEP, 26'h001_0000);
    write_reg(CFG_RECT_WIDTH, 26'd2);
    write_reg(CFG_RECT_HEIGHT, 26'd1);
    repeat (2) draw_pixel(8'($urandom));
  endtask

  // Shrinking the rectangle mid-walk restarts it; zero sides count as one.
  task automatic test_restart();
    wait_idle();
    write_reg(CFG_COLUMN_START, 26'h0);
    write_reg(CFG_ROW_START, 26'h0);
    write_reg(CFG_ROW_STEP, 26'h001_0000);
    write_reg(CFG_TEXTURE_HEIGHT, 26'd64);
    write_reg(CFG_RECT_WIDTH, 26'd3);
    write_reg(CFG_RECT_HEIGHT, 26'd3);
    repeat (4) draw_pixel(8'($urandom));
    wait_idle();
    write_reg(CFG_RECT_HEIGHT, 26'd1);
    draw_pixel(8'($urandom));
    wait_idle();
    write_reg(CFG_RECT_WIDTH, 26'd0);
    write_reg(CFG_RECT_HEIGHT, 26'd0);
    draw_pixel(8'($urandom));
  endtask

  // Saturated side: one full-height column at a fixed texture position.
  task automatic test_full_sides();
    wait_idle();
    write_reg(CFG_COLUMN_STEP, 26'h0);
    write_reg(CFG_ROW_STEP, 26'h0);
    write_reg(CFG_COLUMN_START, 26'($urandom_range(0, 32'h3_FFFF)));
    write_reg(CFG_RECT_WIDTH, 26'h0);
    write_reg(CFG_RECT_HEIGHT, 26'h7FF);
    repeat (MAX_RECT_SIDE) draw_pixel(8'h3C);
  endtask

  // The result side holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_idle();
    write_reg(CFG_COLUMN_STEP, 26'h001_0000);
    write_reg(CFG_ROW_STEP, 26'h000_8000);
    write_reg(CFG_TEXTURE_HEIGHT, 26'd32);
    write_reg(CFG_RECT_WIDTH, 26'd6);
    write_reg(CFG_RECT_HEIGHT, 26'd5);
    write_reg(CFG_EFFECT_FLAGS, 26'd3);
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (40) draw_pixel(8'($urandom));
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned target;
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      random_setup();
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps   = ($urandom_range(0, 3) != 0);
      random_burst($urandom_range(1, 48));
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_streaming();
    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    repeat (2) begin
      random_setup();
      random_burst(30);
    end
  endtask

  // Result side: random stall bursts, or one long hold on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Outputs are sampled mid-cycle; the pixel is taken at the following rising edge.
  always @(negedge clk_i) begin : pixel_check
    out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_queue.size() == 0) begin
        $error("pixel result arrived with no draw pending");
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        check_field("pixel", want.pixel, out_rsp_o.pixel);
        check_field("dest_x", want.dest_x, out_rsp_o.dest_x);
        check_field("dest_y", want.dest_y, out_rsp_o.dest_y);
        check_field("last", want.last, out_rsp_o.last);
        check_field("fault", want.fault, out_rsp_o.fault);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_sequence
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
    test_defaults();
    test_effects();
    test_texel_faults();
    test_restart();
    test_full_sides();
    test_backpressure();
    test_random();
    test_streaming();
    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
